### hdl/pixel_replicate_upscaler_macros.svh
// assertion macros shared by the upscaler modules
`ifndef PIXEL_REPLICATE_UPSCALER_MACROS_SVH
`define PIXEL_REPLICATE_UPSCALER_MACROS_SVH

// checked only while out of reset
`define PRU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define PRU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### hdl/pru_pkg.sv
// shared types and constants of the pixel replicate upscaler
package pru_pkg;

    localparam int PIX_W         = 24;
    localparam int SCALE_W       = 7;
    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 13;
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;
    localparam int SCALE_MAX     = 100;
    localparam int MAX_IN_HEIGHT = 4096;
    // largest width the 11-bit register can express
    localparam int COL_MAX       = 2047;

    // result queue in the back end, ahead of the output
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    localparam logic [1:0] REG_SCALE     = 2'd0;
    localparam logic [1:0] REG_IN_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IN_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_PAD   = 2'd1,
        KIND_NONE  = 2'd2
    } t_kind;

    // classified fetch request from the front
    typedef struct packed {
        logic  valid;
        logic  is_pixel;
        t_kind kind;
        logic  row_end;
        logic  image_end;
    } t_req;

    // one finished result item
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        t_kind            kind;
        logic             row_end;
        logic             image_end;
    } t_res;

endpackage

### hdl/pru_chan_if.sv
// request and result channel interfaces of the upscaler
interface pru_in_if import pru_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [PIX_W-1:0] pixel_in;

    modport source(output valid, output action, output pixel_in, input ready);
    modport sink(input valid, input action, input pixel_in, output ready);
endinterface

interface pru_out_if import pru_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    t_kind            kind;
    logic             row_end;
    logic             image_end;

    modport source(output valid, output pixel_out, output kind, output row_end,
                   output image_end, input ready);
    modport sink(input valid, input pixel_out, input kind, input row_end,
                 input image_end, output ready);
endinterface

### hdl/pru_ram.sv
// generic single-write, registered-read ram
module pru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/pru_front.sv
// front end: accepts requests, keeps the row and image counters, issues ram accesses
`include "pixel_replicate_upscaler_macros.svh"

module pru_front import pru_pkg::*; #(
    parameter int AW = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,
    input  logic [SCALE_W-1:0]  i_eff_scale,
    input  logic [WIDTH_W-1:0]  i_eff_width,
    input  logic [HEIGHT_W-1:0] i_eff_height,
    input  logic [1:0]          i_pad,
    input  logic                i_space,
    pru_in_if.sink              i_req,
    output logic                o_ram_we,
    output logic [AW-1:0]       o_ram_waddr,
    output logic [PIX_W-1:0]    o_ram_wdata,
    output logic                o_ram_re,
    output logic [AW-1:0]       o_ram_raddr,
    output t_req                o_req
);

    logic [WIDTH_W-1:0]  r_load_col, n_load_col;
    logic                r_row_ready, n_row_ready;
    logic [SCALE_W-1:0]  r_copy, n_copy;
    logic [WIDTH_W-1:0]  r_src_col, n_src_col;
    logic [SCALE_W-1:0]  r_rep_row, n_rep_row;
    logic [1:0]          r_pad_left, n_pad_left;
    logic [HEIGHT_W-1:0] r_rows_done, n_rows_done;
    logic                r_img_done, n_img_done;
    logic                accept;
    logic                line_done;

    assign i_req.ready = i_space;
    assign accept      = i_req.valid && i_space;

    always_comb begin
        n_load_col  = r_load_col;
        n_row_ready = r_row_ready;
        n_copy      = r_copy;
        n_src_col   = r_src_col;
        n_rep_row   = r_rep_row;
        n_pad_left  = r_pad_left;
        n_rows_done = r_rows_done;
        n_img_done  = r_img_done;
        line_done   = 1'b0;

        o_ram_we          = 1'b0;
        o_ram_waddr       = r_load_col[AW-1:0];
        o_ram_wdata       = i_req.pixel_in;
        o_ram_re          = 1'b0;
        o_ram_raddr       = r_src_col[AW-1:0];
        o_req.valid       = 1'b0;
        o_req.is_pixel    = 1'b0;
        o_req.kind        = KIND_NONE;
        o_req.row_end     = 1'b0;
        o_req.image_end   = 1'b0;

        if (i_restart) begin
            n_load_col  = '0;
            n_row_ready = 1'b0;
            n_copy      = '0;
            n_src_col   = '0;
            n_rep_row   = '0;
            n_pad_left  = '0;
            n_rows_done = '0;
            n_img_done  = 1'b0;
        end else if (accept) begin
            if (i_req.action == ACT_LOAD) begin
                if (!r_row_ready && !r_img_done && (r_load_col < i_eff_width)) begin
                    o_ram_we   = 1'b1;
                    n_load_col = r_load_col + 1'b1;
                    if (n_load_col >= i_eff_width) begin
                        n_load_col  = '0;
                        n_row_ready = 1'b1;
                        n_copy      = '0;
                        n_src_col   = '0;
                        n_rep_row   = '0;
                        n_pad_left  = '0;
                    end
                end
            end else begin
                o_req.valid = 1'b1;
                if (!r_row_ready || r_img_done) begin
                    o_req.kind = KIND_NONE;
                end else if (r_pad_left == 2'd0) begin
                    o_req.kind     = KIND_PIXEL;
                    o_req.is_pixel = 1'b1;
                    o_ram_re       = 1'b1;
                    n_copy         = r_copy + 1'b1;
                    if (n_copy >= i_eff_scale) begin
                        n_copy    = '0;
                        n_src_col = r_src_col + 1'b1;
                        if (n_src_col >= i_eff_width) begin
                            n_src_col = '0;
                            if (i_pad != 2'd0) begin
                                n_pad_left = i_pad;
                            end else begin
                                line_done = 1'b1;
                            end
                        end
                    end
                end else begin
                    o_req.kind = KIND_PAD;
                    n_pad_left = r_pad_left - 1'b1;
                    if (n_pad_left == 2'd0) begin
                        line_done = 1'b1;
                    end
                end

                if (line_done) begin
                    o_req.row_end = 1'b1;
                    n_rep_row     = r_rep_row + 1'b1;
                    if (n_rep_row >= i_eff_scale) begin
                        n_rep_row   = '0;
                        n_row_ready = 1'b0;
                        n_rows_done = r_rows_done + 1'b1;
                        if (n_rows_done >= i_eff_height) begin
                            n_img_done      = 1'b1;
                            o_req.image_end = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_col  <= '0;
            r_row_ready <= 1'b0;
            r_copy      <= '0;
            r_src_col   <= '0;
            r_rep_row   <= '0;
            r_pad_left  <= '0;
            r_rows_done <= '0;
            r_img_done  <= 1'b0;
        end else begin
            r_load_col  <= n_load_col;
            r_row_ready <= n_row_ready;
            r_copy      <= n_copy;
            r_src_col   <= n_src_col;
            r_rep_row   <= n_rep_row;
            r_pad_left  <= n_pad_left;
            r_rows_done <= n_rows_done;
            r_img_done  <= n_img_done;
        end
    end

    `PRU_ASSERT(a_pad_only_in_row, r_pad_left != 2'd0 |-> r_row_ready, "pad pending without ready row")
    `PRU_ASSERT(a_done_no_row, r_img_done |-> !r_row_ready, "row ready after image done")
    `PRU_ASSERT(a_counters_in_range, r_row_ready |-> (r_copy < i_eff_scale) && (r_src_col < i_eff_width) && (r_rep_row < i_eff_scale), "fetch counter out of range")
    `PRU_ASSERT(a_load_col_in_range, !r_row_ready |-> r_load_col < i_eff_width, "load column past row width")

endmodule

### hdl/pru_back.sv
// back end: joins ram data with fetch requests and queues the results
`include "pixel_replicate_upscaler_macros.svh"

module pru_back import pru_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req             i_req,
    input  logic [PIX_W-1:0] i_ram_rdata,
    output logic             o_space,
    pru_out_if.source        o_res
);

    logic           r_s1_valid;
    t_req           r_s1;
    t_res           r_q [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_count, n_count;
    logic [QCW-1:0] occupancy;
    logic           push, pop;
    t_res           push_res;
    t_res           head;

    assign push = r_s1_valid;
    assign pop  = o_res.valid && o_res.ready;

    always_comb begin
        push_res.pixel     = r_s1.is_pixel ? i_ram_rdata : '0;
        push_res.kind      = r_s1.kind;
        push_res.row_end   = r_s1.row_end;
        push_res.image_end = r_s1.image_end;
    end

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // the request in flight in the ram stage already owns a queue slot
    assign occupancy = r_count + QCW'(r_s1_valid);
    assign o_space   = occupancy < QCW'(QDEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_count    <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= i_req;
        if (push) begin
            r_q[r_wr_ptr] <= push_res;
        end
    end

    assign head            = r_q[r_rd_ptr];
    assign o_res.valid     = r_count != '0;
    assign o_res.pixel_out = head.pixel;
    assign o_res.kind      = head.kind;
    assign o_res.row_end   = head.row_end;
    assign o_res.image_end = head.image_end;

    `PRU_ASSERT(a_queue_bound, occupancy <= QCW'(QDEPTH), "result queue overrun")
    `PRU_ASSERT(a_push_grows, push && !pop |=> r_count == $past(r_count) + 1'b1, "push lost")
    `PRU_ASSERT(a_pop_shrinks, !push && pop |=> r_count == $past(r_count) - 1'b1, "pop lost")

endmodule

### hdl/pixel_replicate_upscaler.sv
// Integer nearest-neighbor upscaler for 24-bit pixel rows. Load requests fill a
// line store with one input row; fetch requests then return the enlarged row one
// element per request, each pixel repeated scale times across, zero pad bytes to
// a 4-byte boundary, and the row repeated scale times down. One request is taken
// every clock cycle while the result queue has space; a fetch result passes through
// the registered line store read, then the result queue. Input ready drops only
// when the four-entry result queue fills because the output is stalled. Writing
// any of the three registers restarts the image; the line store keeps its contents.
module pixel_replicate_upscaler import pru_pkg::*; #(
    parameter int MAX_IN_WIDTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    pru_in_if.sink             i_req,
    pru_out_if.source          o_res
);

    localparam int LS_DEPTH = (MAX_IN_WIDTH < COL_MAX) ? MAX_IN_WIDTH : COL_MAX;
    localparam int AW       = (LS_DEPTH > 1) ? $clog2(LS_DEPTH) : 1;

    logic [SCALE_W-1:0]  r_scale;
    logic [WIDTH_W-1:0]  r_in_width;
    logic [HEIGHT_W-1:0] r_in_height;
    logic                cfg_wr;
    logic                restart;
    logic [SCALE_W-1:0]  eff_scale;
    logic [WIDTH_W-1:0]  eff_width;
    logic [HEIGHT_W-1:0] eff_height;
    logic [3:0]          ws_low;
    logic [1:0]          pad;
    logic                space;
    t_req                req;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [PIX_W-1:0]    ram_wdata, ram_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_W'(1);
            r_in_width  <= WIDTH_W'(1);
            r_in_height <= HEIGHT_W'(1);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SCALE:     r_scale     <= pwdata[SCALE_W-1:0];
                REG_IN_WIDTH:  r_in_width  <= pwdata[WIDTH_W-1:0];
                REG_IN_HEIGHT: r_in_height <= pwdata[HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        restart = 1'b0;
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_SCALE, REG_IN_WIDTH, REG_IN_HEIGHT: restart = 1'b1;
                default:                                restart = 1'b0;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SCALE:     prdata = PDATA_W'(r_scale);
            REG_IN_WIDTH:  prdata = PDATA_W'(r_in_width);
            REG_IN_HEIGHT: prdata = PDATA_W'(r_in_height);
            default:       prdata = '0;
        endcase
    end

    // out of range values are clamped
    assign eff_scale  = (r_scale == '0) ? SCALE_W'(1) :
                        (r_scale > SCALE_W'(SCALE_MAX)) ? SCALE_W'(SCALE_MAX) : r_scale;
    assign eff_width  = (r_in_width == '0) ? WIDTH_W'(1) :
                        (r_in_width > WIDTH_W'(LS_DEPTH)) ? WIDTH_W'(LS_DEPTH) : r_in_width;
    assign eff_height = (r_in_height == '0) ? HEIGHT_W'(1) :
                        (r_in_height > HEIGHT_W'(MAX_IN_HEIGHT)) ? HEIGHT_W'(MAX_IN_HEIGHT) :
                        r_in_height;

    // pad bytes = (-3*w*s) mod 4 = (w*s) mod 4
    assign ws_low = eff_width[1:0] * eff_scale[1:0];
    assign pad    = ws_low[1:0];

    pru_front #(
        .AW(AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_eff_scale (eff_scale),
        .i_eff_width (eff_width),
        .i_eff_height(eff_height),
        .i_pad       (pad),
        .i_space     (space),
        .i_req       (i_req),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_req       (req)
    );

    pru_ram #(
        .WIDTH(PIX_W),
        .DEPTH(LS_DEPTH)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    pru_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_ram_rdata(ram_rdata),
        .o_space    (space),
        .o_res      (o_res)
    );

endmodule

### tb/sv/testbench.sv
// self-checking testbench of the pixel replicate upscaler: load/fetch requests, register setups
`timescale 1ns / 100ps

module testbench;
    import pru_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int MAX_W       = 1024;
    localparam int HOLD_CYCLES = 8;
    localparam int STAGE_ITEMS = 350;
    localparam int FETCH_CAP   = 200;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel;
    } t_stim;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    pru_in_if  req_if ();
    pru_out_if res_if ();

    pixel_replicate_upscaler #(.MAX_IN_WIDTH(MAX_W)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // register copies and upscaler state as the block should hold them
    logic [SCALE_W-1:0]  sc_reg;
    logic [WIDTH_W-1:0]  wd_reg;
    logic [HEIGHT_W-1:0] ht_reg;
    logic [PIX_W-1:0]    line_mem [MAX_W];
    logic [WIDTH_W-1:0]  load_col;
    logic                row_rdy;
    logic [SCALE_W-1:0]  copy_cnt;
    logic [WIDTH_W-1:0]  src_col;
    logic [SCALE_W-1:0]  rep_row;
    logic [1:0]          pad_cnt;
    logic [HEIGHT_W-1:0] rows_cnt;
    logic                img_done;

    t_res  expected_elems [$];
    t_stim request_q [$];
    int    queued_cnt   = 0;
    int    accepted_cnt = 0;
    int    error_cnt    = 0;
    int    send_gap_pct;
    int    recv_gap_pct;
    logic  took;

    function automatic int unsigned eff_scale(logic [SCALE_W-1:0] v);
        if (v == 0) return 1;
        if (v > SCALE_MAX) return SCALE_MAX;
        return v;
    endfunction

    function automatic int unsigned eff_width(logic [WIDTH_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_W) return MAX_W;
        return v;
    endfunction

    function automatic int unsigned eff_height(logic [HEIGHT_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_IN_HEIGHT) return MAX_IN_HEIGHT;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic string fmt_elem(t_res e);
        return $sformatf("pixel %06h kind %0d row_end %0b image_end %0b",
                         e.pixel, e.kind, e.row_end, e.image_end);
    endfunction

    function automatic void log_error(string msg);
        error_cnt++;
        if (error_cnt <= 10) $display("%0t: %s", $time, msg);
    endfunction

    task automatic restart_image();
        load_col = '0;
        row_rdy  = 1'b0;
        copy_cnt = '0;
        src_col  = '0;
        rep_row  = '0;
        pad_cnt  = '0;
        rows_cnt = '0;
        img_done = 1'b0;
    endtask

    // advance the upscaler state by one accepted request
    task automatic replicate_step(input logic act, input logic [PIX_W-1:0] pix);
        int unsigned s, w, bytes;
        logic        line_done;
        t_res        r;
        s = eff_scale(sc_reg);
        w = eff_width(wd_reg);
        line_done = 1'b0;
        r = '0;
        r.kind = KIND_PIXEL;
        if (act == ACT_LOAD) begin
            if (!row_rdy && !img_done && load_col < w) begin
                line_mem[load_col] = pix;
                load_col++;
                if (load_col >= w) begin
                    load_col = '0;
                    row_rdy  = 1'b1;
                    copy_cnt = '0;
                    src_col  = '0;
                    rep_row  = '0;
                    pad_cnt  = '0;
                end
            end
        end else begin
            if (!row_rdy || img_done) begin
                r.kind = KIND_NONE;
            end else if (pad_cnt == 0) begin
                r.pixel = line_mem[src_col];
                copy_cnt++;
                if (copy_cnt >= s) begin
                    copy_cnt = '0;
                    src_col++;
                    if (src_col >= w) begin
                        bytes     = w * s * 3;
                        src_col   = '0;
                        pad_cnt   = (4 - (bytes & 3)) & 3;
                        line_done = (pad_cnt == 0);
                    end
                end
            end else begin
                r.kind = KIND_PAD;
                pad_cnt--;
                line_done = (pad_cnt == 0);
            end
            if (line_done) begin
                r.row_end = 1'b1;
                rep_row++;
                if (rep_row >= s) begin
                    rep_row = '0;
                    row_rdy = 1'b0;
                    rows_cnt++;
                    if (rows_cnt >= eff_height(ht_reg)) begin
                        img_done    = 1'b1;
                        r.image_end = 1'b1;
                    end
                end
            end
            expected_elems.push_back(r);
        end
    endtask

    task automatic push_req(input logic act, input logic [PIX_W-1:0] pix);
        t_stim t;
        t.action = act;
        t.pixel  = pix;
        request_q.push_back(t);
        queued_cnt++;
    endtask

    // wait until every request is taken and every element is back
    task automatic drain_all();
        while (accepted_cnt != queued_cnt || expected_elems.size() != 0)
            @(posedge i_clk);
        // loads leave no element behind, so give the pipeline time to settle
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input int unsigned val);
        logic [PDATA_W-1:0] data;
        data = val;
        // bits above the field must be dropped by the block
        if ($urandom_range(3) == 0) begin
            case (idx)
                REG_SCALE:     data[PDATA_W-1:SCALE_W]  = $urandom;
                REG_IN_WIDTH:  data[PDATA_W-1:WIDTH_W]  = $urandom;
                REG_IN_HEIGHT: data[PDATA_W-1:HEIGHT_W] = $urandom;
                default: ;
            endcase
        end
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_SCALE: begin
                sc_reg = data[SCALE_W-1:0];
                restart_image();
            end
            REG_IN_WIDTH: begin
                wd_reg = data[WIDTH_W-1:0];
                restart_image();
            end
            REG_IN_HEIGHT: begin
                ht_reg = data[HEIGHT_W-1:0];
                restart_image();
            end
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // set up one image and queue its rows, with stray requests mixed in
    task automatic queue_image(input int unsigned sc, input int unsigned wd,
                               input int unsigned ht, input int unsigned rows_max,
                               output int made);
        int unsigned s, w, rows, bytes, per_row, k;
        int          first, stray;
        drain_all();
        apb_write(REG_SCALE, sc);
        apb_write(REG_IN_WIDTH, wd);
        apb_write(REG_IN_HEIGHT, ht);
        s     = eff_scale(sc_reg);
        w     = eff_width(wd_reg);
        rows  = eff_height(ht_reg);
        if (rows > rows_max) rows = rows_max;
        bytes   = w * s * 3;
        per_row = (w * s + ((4 - (bytes & 3)) & 3)) * s;
        // very long rows are cut short, the next setup restarts the image
        if (per_row > FETCH_CAP) per_row = FETCH_CAP;
        first = queued_cnt;
        stray = 0;
        repeat (rows) begin
            if ($urandom_range(3) == 0) push_req(ACT_FETCH, rand_pixel());
            for (k = 0; k < w; k++) begin
                push_req(ACT_LOAD, rand_pixel());
                if (k + 1 < w && $urandom_range(15) == 0) push_req(ACT_FETCH, rand_pixel());
            end
            for (k = 0; k < per_row; k++) begin
                // loads while the row is being sent are dropped
                if ($urandom_range(19) == 0) begin
                    push_req(ACT_LOAD, rand_pixel());
                    stray++;
                end
                push_req(ACT_FETCH, rand_pixel());
            end
        end
        if (rows == eff_height(ht_reg)) begin
            repeat ($urandom_range(1, 2)) push_req(ACT_FETCH, rand_pixel());
            push_req(ACT_LOAD, rand_pixel());
            stray++;
        end
        made = queued_cnt - first - stray;
    endtask

    task automatic run_stage(input int snd, input int rcv, input int unsigned x_sc,
                             input int unsigned x_wd, input int unsigned x_ht,
                             input int unsigned x_rows);
        int          made, total;
        int unsigned sc, wd, ht;
        send_gap_pct = snd;
        recv_gap_pct = rcv;
        queue_image(x_sc, x_wd, x_ht, x_rows, made);
        total = made;
        while (total < STAGE_ITEMS) begin
            sc = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 5);
            wd = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 8);
            ht = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 3);
            queue_image(sc, wd, ht, 3, made);
            total += made;
        end
    endtask

    always @(negedge i_clk) begin : drive_requests
        t_stim nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || took) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                nxt = request_q.pop_front();
                req_if.valid    <= 1'b1;
                req_if.action   <= nxt.action;
                req_if.pixel_in <= nxt.pixel;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_res got, want;
        if (!i_rst_n) begin
            took <= 1'b0;
        end else begin
            took <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) begin
                replicate_step(req_if.action, req_if.pixel_in);
                accepted_cnt++;
            end
            if (res_if.valid && res_if.ready) begin
                got.pixel     = res_if.pixel_out;
                got.kind      = res_if.kind;
                got.row_end   = res_if.row_end;
                got.image_end = res_if.image_end;
                if (expected_elems.size() == 0) begin
                    log_error({"unexpected element: ", fmt_elem(got)});
                end else begin
                    want = expected_elems.pop_front();
                    if (got.pixel !== want.pixel || got.kind !== want.kind ||
                        got.row_end !== want.row_end || got.image_end !== want.image_end) begin
                        log_error({"expected ", fmt_elem(want), ", got ", fmt_elem(got)});
                    end
                end
            end
        end
    end

    initial begin : stimulus
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_if.valid    = 1'b0;
        req_if.action   = ACT_LOAD;
        req_if.pixel_in = '0;
        res_if.ready    = 1'b0;
        sc_reg = 1;
        wd_reg = 1;
        ht_reg = 1;
        restart_image();
        send_gap_pct = 13;
        recv_gap_pct = 85;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setup: one pixel, one pad byte, one row
        push_req(ACT_FETCH, 24'hFFFFFF);
        push_req(ACT_LOAD, 24'hFFFFFF);
        push_req(ACT_LOAD, 24'h000000);
        push_req(ACT_FETCH, 24'h000000);
        push_req(ACT_FETCH, 24'hFFFFFF);
        push_req(ACT_FETCH, 24'h5A5A5A);
        push_req(ACT_LOAD, 24'h123456);
        drain_all();

        // zero registers act as one; the unmapped address changes nothing
        apb_write(REG_SCALE, 0);
        apb_write(REG_IN_WIDTH, 0);
        apb_write(REG_IN_HEIGHT, 0);
        apb_write(REG_UNUSED, $urandom);
        push_req(ACT_LOAD, 24'h000000);
        push_req(ACT_FETCH, 24'hA5A5A5);
        push_req(ACT_FETCH, 24'hFFFFFF);
        push_req(ACT_FETCH, 24'h000000);
        push_req(ACT_LOAD, 24'hFFFFFF);

        run_stage(13, 85, 0, 2047, 0, 1);
        run_stage(85, 13, 2, 3, 8191, 2);
        run_stage(0, 0, 127, 1, 1, 1);

        drain_all();
        if (error_cnt == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/pru_pkg.sv
hdl/pru_chan_if.sv
hdl/pru_ram.sv
hdl/pru_front.sv
hdl/pru_back.sv
hdl/pixel_replicate_upscaler.sv
tb/sv/testbench.sv
